// ===== rtl/nida_pkg.sv =====
// Shared codes and types for the node identifier allocation table.
package nida_pkg;

   localparam int UID_W    = 32;
   localparam int NID_W    = 5;
   localparam int STATUS_W = 3;

   typedef enum logic {
      OP_REQUEST = 1'b0,
      OP_DELETE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_PRESENT   = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_DELETED   = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

endpackage

// ===== rtl/nida_if.sv =====
// Request and response channel interfaces of the node identifier allocation table.
interface nida_req_if;
   logic                         valid;
   logic                         ready;
   nida_pkg::op_type             operation;
   logic [nida_pkg::UID_W-1:0]   unique_id;
   logic [nida_pkg::NID_W-1:0]   node_id;

   modport source (output valid, operation, unique_id, node_id, input ready);
   modport sink   (input valid, operation, unique_id, node_id, output ready);
endinterface

interface nida_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [nida_pkg::NID_W-1:0]   assigned_id;
   nida_pkg::status_type         status;
   logic [nida_pkg::NID_W-1:0]   occupied_count;

   modport source (output valid, assigned_id, status, occupied_count, input ready);
   modport sink   (input valid, assigned_id, status, occupied_count, output ready);
endinterface

// ===== rtl/nida_ram.sv =====
// Generic single write port RAM with registered read.
module nida_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/node_id_allocation_table.sv =====
// Node identifier allocation table: maps 32-bit unique identifiers to small slot numbers.
//
// A transaction on req_ch either registers unique_id (operation request) or frees
// slot node_id (operation delete). Each accepted transaction yields exactly one
// transaction on rsp_ch carrying the slot, a status code and the occupancy after it.
// Slot 0 is never handed out.
//
// A request walks slots 1..TABLE_SLOTS-1 one per cycle through the identifier RAM
// read port, comparing each occupied entry and noting the lowest free one. The
// response register loads in DONE once the last slot has been compared, and the next
// transaction is taken after the return to IDLE; a delete skips the walk and goes
// from IDLE straight to DONE.
// req_ch.ready is high only while no transaction is in work, so one transaction is
// processed at a time; the next may be accepted while the previous response still
// waits on rsp_ch.
// If rsp_ch stalls, the finished result holds in the sequencer until the response
// register frees up.
// Reset clears all occupancy flags and the count; the identifier RAM needs no
// clearing pass since only occupied entries are ever compared.
module node_id_allocation_table #(
   parameter int TABLE_SLOTS = 32
) (
   input  logic       clock,
   input  logic       reset,
   nida_req_if.sink   req_ch,
   nida_rsp_if.source rsp_ch
);

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int OUT_W = (IDX_W > nida_pkg::NID_W) ? IDX_W : nida_pkg::NID_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   nida_pkg::op_type               op_ff, op_in;
   logic [nida_pkg::UID_W-1:0]     uid_ff, uid_in;
   logic [nida_pkg::NID_W-1:0]     nid_ff, nid_in;
   logic [IDX_W-1:0]               rd_idx_ff, rd_idx_in;
   logic                           issue_ff, issue_in;
   logic                           cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]               cmp_idx_ff, cmp_idx_in;
   logic                           found_ff, found_in;
   logic [IDX_W-1:0]               found_idx_ff, found_idx_in;
   logic                           free_ff, free_in;
   logic [IDX_W-1:0]               free_idx_ff, free_idx_in;
   logic                           occ_ff [TABLE_SLOTS];
   logic                           occ_in [TABLE_SLOTS];
   logic [IDX_W-1:0]               cnt_ff, cnt_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic [nida_pkg::NID_W-1:0]     rsp_id_ff, rsp_id_in;
   nida_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [nida_pkg::NID_W-1:0]     rsp_cnt_ff, rsp_cnt_in;

   logic                           req_accept;
   logic                           out_free;
   logic [nida_pkg::UID_W-1:0]     ram_rd_data;
   logic                           ram_wr_en;
   logic                           hit;
   logic [OUT_W-1:0]               nid_wide;
   logic [IDX_W-1:0]               del_idx;
   logic                           del_ok;
   logic [OUT_W-1:0]               found_wide;
   logic [OUT_W-1:0]               free_wide;
   logic [OUT_W-1:0]               cnt_wide;

   nida_ram #(
      .WIDTH (nida_pkg::UID_W),
      .DEPTH (TABLE_SLOTS)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (uid_ff),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_vld_ff || rsp_ch.ready;

   assign hit        = occ_ff[cmp_idx_ff] && (ram_rd_data == uid_ff);
   assign nid_wide   = OUT_W'(nid_ff);
   assign del_idx    = nid_wide[IDX_W-1:0];
   assign del_ok     = (nid_ff != '0) && (32'(nid_ff) < 32'(TABLE_SLOTS)) && occ_ff[del_idx];
   assign found_wide = OUT_W'(found_idx_ff);
   assign free_wide  = OUT_W'(free_idx_ff);

   assign ram_wr_en = (state_ff == ST_DONE) && out_free && (op_ff == nida_pkg::OP_REQUEST)
                      && !found_ff && free_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      uid_in        = uid_ff;
      nid_in        = nid_ff;
      rd_idx_in     = rd_idx_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = rd_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      occ_in        = occ_ff;
      cnt_in        = cnt_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_ch.ready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      cnt_wide      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in       = req_ch.operation;
               uid_in      = req_ch.unique_id;
               nid_in      = req_ch.node_id;
               rd_idx_in   = IDX_W'(1);
               issue_in    = 1'b1;
               found_in    = 1'b0;
               free_in     = 1'b0;
               state_in    = (req_ch.operation == nida_pkg::OP_REQUEST) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            // address stage: issue the next slot read
            if (issue_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff;
               if (rd_idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            // compare stage: RAM data belongs to cmp_idx_ff
            if (cmp_vld_ff) begin
               if (hit && !found_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = cmp_idx_ff;
               end
               if (!occ_ff[cmp_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
               rsp_id_in  = '0;
               cnt_in     = cnt_ff;
               if (op_ff == nida_pkg::OP_REQUEST) begin
                  if (found_ff) begin
                     rsp_id_in     = found_wide[nida_pkg::NID_W-1:0];
                     rsp_status_in = nida_pkg::STATUS_PRESENT;
                  end else if (free_ff) begin
                     occ_in[free_idx_ff] = 1'b1;
                     cnt_in              = cnt_ff + IDX_W'(1);
                     rsp_id_in           = free_wide[nida_pkg::NID_W-1:0];
                     rsp_status_in       = nida_pkg::STATUS_INSERTED;
                  end else begin
                     rsp_status_in = nida_pkg::STATUS_FULL;
                  end
               end else begin
                  if (del_ok) begin
                     occ_in[del_idx] = 1'b0;
                     cnt_in          = (cnt_ff != '0) ? cnt_ff - IDX_W'(1) : cnt_ff;
                     rsp_status_in   = nida_pkg::STATUS_DELETED;
                  end else begin
                     rsp_status_in = nida_pkg::STATUS_NOT_FOUND;
                  end
               end
               cnt_wide   = OUT_W'(cnt_in);
               rsp_cnt_in = cnt_wide[nida_pkg::NID_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         issue_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         free_ff    <= 1'b0;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            occ_ff[i] <= 1'b0;
         end
      end else begin
         state_ff   <= state_in;
         issue_ff   <= issue_in;
         cmp_vld_ff <= cmp_vld_in;
         found_ff   <= found_in;
         free_ff    <= free_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
         occ_ff     <= occ_in;
      end
      op_ff         <= op_in;
      uid_ff        <= uid_in;
      nid_ff        <= nid_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_idx_ff  <= found_idx_in;
      free_idx_ff   <= free_idx_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.assigned_id    = rsp_id_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.occupied_count = rsp_cnt_ff;

endmodule

// ===== rtl/nida_chk.sv =====
// Port-level assertion checker for the node identifier allocation table, with its bind.
module nida_chk #(
   parameter int TABLE_SLOTS = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [nida_pkg::NID_W-1:0]   assigned_id,
   input nida_pkg::status_type         status,
   input logic [nida_pkg::NID_W-1:0]   occupied_count
);

   localparam logic [31:0] FULL_COUNT = 32'(TABLE_SLOTS - 1);

   // one transaction in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in work");

   // full means every usable slot is taken and nothing is assigned
   a_full_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == nida_pkg::STATUS_FULL |->
         assigned_id == '0 && occupied_count == FULL_COUNT[nida_pkg::NID_W-1:0])
      else $error("full status with inconsistent slot or count");

   // deletes never report a slot
   a_delete_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == nida_pkg::STATUS_DELETED ||
                    status == nida_pkg::STATUS_NOT_FOUND) |-> assigned_id == '0)
      else $error("delete response carries a slot number");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(assigned_id) && $stable(status)
         && $stable(occupied_count))
      else $error("response changed while stalled");

endmodule

bind node_id_allocation_table nida_chk #(.TABLE_SLOTS(TABLE_SLOTS)) u_nida_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .assigned_id    (rsp_ch.assigned_id),
   .status         (rsp_ch.status),
   .occupied_count (rsp_ch.occupied_count)
);
